### sv/assert_macros.svh
// Assertion macros shared by the ALU RTL.
// No dependencies; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ALU_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ALU_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
    lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/x86alu_pkg.sv
// Shared types and constants for the x86 integer ALU with kept flags.
// No dependencies; used by x86alu_core and x86_alu_with_flags_top.
package x86alu_pkg;

    localparam int WORD_BITS = 32;
    localparam int PROD_BITS = 2 * WORD_BITS;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_ADC = 4'd1,
        CMD_SUB = 4'd2,
        CMD_SBB = 4'd3,
        CMD_AND = 4'd4,
        CMD_OR  = 4'd5,
        CMD_XOR = 4'd6,
        CMD_MUL = 4'd7,
        CMD_SHL = 4'd8,
        CMD_SAL = 4'd9,
        CMD_SHR = 4'd10,
        CMD_SAR = 4'd11
    } alu_cmd_t;

    localparam logic [1:0] SZ_BYTE  = 2'd0;
    localparam logic [1:0] SZ_WORD  = 2'd1;
    localparam logic [1:0] SZ_DWORD = 2'd2;

    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic pf;
        logic cf;
    } alu_flags_t;

endpackage

### sv/x86alu_core.sv
// Combinational datapath of the ALU: result and new flags for one operation.
// Depends on x86alu_pkg.
module x86alu_core
    import x86alu_pkg::*;
(
    input  logic [3:0]                 cmd,
    input  logic [WORD_BITS-1:0]       src_operand,
    input  logic [WORD_BITS-1:0]       dest_operand,
    input  logic [1:0]                 operand_size,
    input  alu_flags_t                 flags_in,
    output logic [PROD_BITS-1:0]       result,
    output alu_flags_t                 flags_out
);

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] src_lo;
    logic [WORD_BITS-1:0] dst_lo;
    logic [WORD_BITS-1:0] dst_hi;
    logic [WORD_BITS-1:0] dst_sx;
    logic [4:0]           cnt;
    logic                 cin;
    logic [WORD_BITS:0]   add_full;
    logic [WORD_BITS:0]   sub_full;
    logic [WORD_BITS-1:0] logic_res;
    logic [PROD_BITS-1:0] prod;
    logic                 prod_hi_set;
    logic                 prod_sign;
    logic [PROD_BITS-1:0] shl_wide;
    logic [WORD_BITS:0]   shr_wide;
    logic [WORD_BITS:0]   sar_wide;
    logic [WORD_BITS-1:0] shift_lo;
    logic [WORD_BITS-1:0] shift_res;
    logic                 shift_cf;
    logic                 shl_out_bit;
    logic                 lo_msb;
    logic                 new_msb;

    always_comb
    begin
        case (operand_size)
            SZ_BYTE:
            begin
                mask = 32'h0000_00ff;
            end
            SZ_WORD:
            begin
                mask = 32'h0000_ffff;
            end
            default:
            begin
                mask = 32'hffff_ffff;
            end
        endcase
    end

    assign src_lo = src_operand & mask;
    assign dst_lo = dest_operand & mask;
    assign dst_hi = dest_operand & ~mask;
    assign cnt    = src_operand[4:0];

    // Carry or borrow in is only used by adc and sbb.
    assign cin = flags_in.cf && ((cmd == CMD_ADC) || (cmd == CMD_SBB));

    assign add_full = {1'b0, dest_operand} + {1'b0, src_operand} + {{WORD_BITS{1'b0}}, cin};
    assign sub_full = {1'b0, dest_operand} - {1'b0, src_operand} - {{WORD_BITS{1'b0}}, cin};

    always_comb
    begin
        case (cmd)
            CMD_AND:
            begin
                logic_res = src_operand & dest_operand;
            end
            CMD_OR:
            begin
                logic_res = src_operand | dest_operand;
            end
            default:
            begin
                logic_res = src_operand ^ dest_operand;
            end
        endcase
    end

    // Operands are already masked to the size, so the product never
    // carries bits above twice the size.
    assign prod = PROD_BITS'(src_lo) * PROD_BITS'(dst_lo);

    always_comb
    begin
        case (operand_size)
            SZ_BYTE:
            begin
                prod_hi_set = (prod[15:8] != 8'd0);
                prod_sign   = prod[15];
                dst_sx      = {{24{dst_lo[7]}}, dst_lo[7:0]};
                shl_out_bit = shl_wide[8];
                lo_msb      = dst_lo[7];
            end
            SZ_WORD:
            begin
                prod_hi_set = (prod[31:16] != 16'd0);
                prod_sign   = prod[31];
                dst_sx      = {{16{dst_lo[15]}}, dst_lo[15:0]};
                shl_out_bit = shl_wide[16];
                lo_msb      = dst_lo[15];
            end
            default:
            begin
                prod_hi_set = (prod[63:32] != 32'd0);
                prod_sign   = prod[63];
                dst_sx      = dst_lo;
                shl_out_bit = shl_wide[32];
                lo_msb      = dst_lo[31];
            end
        endcase
    end

    // The top bit of the shifted part is picked in its own block, since the
    // shifted part itself depends on the sign extension decoded above.
    always_comb
    begin
        case (operand_size)
            SZ_BYTE:
            begin
                new_msb = shift_lo[7];
            end
            SZ_WORD:
            begin
                new_msb = shift_lo[15];
            end
            default:
            begin
                new_msb = shift_lo[31];
            end
        endcase
    end

    // Each shifter carries one extra bit so the last bit shifted out is
    // available as CF without a separate select on the count.
    assign shl_wide = {{WORD_BITS{1'b0}}, dst_lo} << cnt;
    assign shr_wide = {dst_lo, 1'b0} >> cnt;
    assign sar_wide = $signed({dst_sx, 1'b0}) >>> cnt;

    always_comb
    begin
        case (cmd)
            CMD_SHL, CMD_SAL:
            begin
                shift_lo = shl_wide[WORD_BITS-1:0] & mask;
                shift_cf = shl_out_bit;
            end
            CMD_SHR:
            begin
                shift_lo = shr_wide[WORD_BITS:1];
                shift_cf = shr_wide[0];
            end
            default:
            begin
                shift_lo = sar_wide[WORD_BITS:1] & mask;
                shift_cf = sar_wide[0];
            end
        endcase
        if (cnt == 5'd0)
        begin
            shift_lo = dst_lo;
        end
    end

    assign shift_res = dst_hi | shift_lo;

    always_comb
    begin
        result    = '0;
        flags_out = flags_in;
        case (cmd)
            CMD_ADD, CMD_ADC:
            begin
                result       = {{WORD_BITS{1'b0}}, add_full[WORD_BITS-1:0]};
                flags_out.cf = add_full[WORD_BITS];
                flags_out.of = ~(dest_operand[31] ^ src_operand[31])
                               & (dest_operand[31] ^ add_full[31]);
                flags_out.zf = (add_full[WORD_BITS-1:0] == '0);
                flags_out.sf = add_full[31];
                flags_out.pf = ~^add_full[7:0];
            end
            CMD_SUB, CMD_SBB:
            begin
                result       = {{WORD_BITS{1'b0}}, sub_full[WORD_BITS-1:0]};
                flags_out.cf = sub_full[WORD_BITS];
                flags_out.of = (dest_operand[31] ^ src_operand[31])
                               & (dest_operand[31] ^ sub_full[31]);
                flags_out.zf = (sub_full[WORD_BITS-1:0] == '0);
                flags_out.sf = sub_full[31];
                flags_out.pf = ~^sub_full[7:0];
            end
            CMD_AND, CMD_OR, CMD_XOR:
            begin
                result       = {{WORD_BITS{1'b0}}, logic_res};
                flags_out.cf = 1'b0;
                flags_out.of = 1'b0;
                flags_out.zf = (logic_res == '0);
                flags_out.sf = logic_res[31];
                flags_out.pf = ~^logic_res[7:0];
            end
            CMD_MUL:
            begin
                result       = prod;
                flags_out.cf = prod_hi_set;
                flags_out.of = prod_hi_set;
                flags_out.zf = (prod == '0);
                flags_out.sf = prod_sign;
                flags_out.pf = ~^prod[7:0];
            end
            CMD_SHL, CMD_SAL, CMD_SHR, CMD_SAR:
            begin
                result       = {{WORD_BITS{1'b0}}, shift_res};
                flags_out.zf = (shift_lo == '0);
                flags_out.sf = new_msb;
                flags_out.pf = ~^shift_res[7:0];
                // A zero count leaves CF and OF alone; OF changes only
                // for a count of one.
                if (cnt != 5'd0)
                begin
                    flags_out.cf = shift_cf;
                end
                if (cnt == 5'd1)
                begin
                    if (cmd == CMD_SHR)
                    begin
                        flags_out.of = lo_msb;
                    end
                    else if (cmd == CMD_SAR)
                    begin
                        flags_out.of = 1'b0;
                    end
                    else
                    begin
                        flags_out.of = new_msb ^ shift_cf;
                    end
                end
            end
            default:
            begin
                result    = '0;
                flags_out = flags_in;
            end
        endcase
    end

endmodule

### sv/x86_alu_with_flags_top.sv
// Top level of the x86 integer ALU that keeps CF, PF, ZF, SF and OF.
// Depends on x86alu_pkg, x86alu_core and assert_macros.svh.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------------
//   input    | in_valid / in_ready    | cmd, src_operand, dest_operand, operand_size
//   output   | out_valid / out_ready  | result_value, carry_out .. overflow_out
//
// A transaction is captured in the input register at the accepting edge, computed
// combinationally from there and written to the result register at the edge where
// it leaves the input register, which also raises out_valid.
// One transaction is accepted every cycle unless the output stalls; the kept flags
// are written in the same edge as the result, so adc and sbb see the flags of the previous one.
// The flag outputs are the kept flags themselves; reset clears them and both
// valid bits. A stalled output holds the result and stops the input register.
module x86_alu_with_flags_top
    import x86alu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           cmd,
    input  logic [WORD_BITS-1:0] src_operand,
    input  logic [WORD_BITS-1:0] dest_operand,
    input  logic [1:0]           operand_size,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PROD_BITS-1:0] result_value,
    output logic                 carry_out,
    output logic                 parity_out,
    output logic                 zero_out,
    output logic                 sign_out,
    output logic                 overflow_out
);

`include "assert_macros.svh"

    logic                 s1_valid_reg;
    logic [3:0]           s1_cmd_reg;
    logic [WORD_BITS-1:0] s1_src_reg;
    logic [WORD_BITS-1:0] s1_dst_reg;
    logic [1:0]           s1_size_reg;
    logic                 out_valid_reg;
    logic [PROD_BITS-1:0] result_reg;
    alu_flags_t           flags_reg;

    logic                 s1_advance;
    logic                 in_take;
    logic [PROD_BITS-1:0] result_next;
    alu_flags_t           flags_next;

    logic                 adv_logic;
    logic                 adv_mul;
    logic                 adv_unused;
    logic                 cf_of_set;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_take    = in_valid && in_ready;

    x86alu_core u_core (
        .cmd          (s1_cmd_reg),
        .src_operand  (s1_src_reg),
        .dest_operand (s1_dst_reg),
        .operand_size (s1_size_reg),
        .flags_in     (flags_reg),
        .result       (result_next),
        .flags_out    (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg  <= cmd;
            s1_src_reg  <= src_operand;
            s1_dst_reg  <= dest_operand;
            s1_size_reg <= operand_size;
        end
        if (s1_advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign carry_out    = flags_reg.cf;
    assign parity_out   = flags_reg.pf;
    assign zero_out     = flags_reg.zf;
    assign sign_out     = flags_reg.sf;
    assign overflow_out = flags_reg.of;

    assign adv_logic  = s1_advance && (s1_cmd_reg inside {CMD_AND, CMD_OR, CMD_XOR});
    assign adv_mul    = s1_advance && (s1_cmd_reg == CMD_MUL);
    assign adv_unused = s1_advance && (s1_cmd_reg > CMD_SAR);
    assign cf_of_set  = carry_out || overflow_out;

    // The kept flags may only change when a transaction leaves the input register.
    `ALU_ASSERT(a_flags_hold, clk, rst_n, !s1_advance |=> $stable(flags_reg), "flags moved idle")

    // Logic operations always clear CF and OF.
    `ALU_ASSERT(a_logic_clears, clk, rst_n, adv_logic |=> !cf_of_set, "logic op left CF or OF set")

    // Multiply sets CF and OF together.
    `ALU_ASSERT(a_mul_cf, clk, rst_n, adv_mul |=> carry_out == overflow_out, "mul CF and OF differ")

    // An unused command yields zero and keeps every flag.
    `ALU_ASSERT(a_unused_zero, clk, rst_n, adv_unused |=> result_reg == '0, "unused cmd result")
    `ALU_ASSERT(a_unused_keep, clk, rst_n, adv_unused |=> $stable(flags_reg), "unused cmd flags")

    // No result is offered once reset has been seen at a clock edge.
    `ALU_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid_reg, "out_valid high in reset")

endmodule
